>>> sv/rsb_pkg.sv
// ----------------------------------------------------------------------------
// rsb_pkg
// shared types and constants of the run-length sprite blitter
// ----------------------------------------------------------------------------
package rsb_pkg;

   // framebuffer addresses wrap at 2**ADDR_W bytes
   localparam int ADDR_W = 16;

   // configuration register indexes
   localparam logic [2:0] CSR_BLEND_MODE    = 3'd0;
   localparam logic [2:0] CSR_COLOR_BANK    = 3'd1;
   localparam logic [2:0] CSR_BRIGHTNESS    = 3'd2;
   localparam logic [2:0] CSR_SPRITE_WIDTH  = 3'd3;
   localparam logic [2:0] CSR_SPRITE_HEIGHT = 3'd4;
   localparam logic [2:0] CSR_LINE_PITCH    = 3'd5;
   localparam logic [2:0] CSR_ORIGIN_X      = 3'd6;
   localparam logic [2:0] CSR_ORIGIN_Y      = 3'd7;

   // blend modes
   localparam logic [2:0] MODE_BRIGHT        = 3'd0;
   localparam logic [2:0] MODE_SHADOW        = 3'd1;
   localparam logic [2:0] MODE_DARKEN        = 3'd2;
   localparam logic [2:0] MODE_TRICK         = 3'd3;
   localparam logic [2:0] MODE_MODIFY        = 3'd4;
   localparam logic [2:0] MODE_ADJUST        = 3'd5;
   localparam logic [2:0] MODE_BRIGHT_DARKEN = 3'd6;

   // stream codes
   localparam logic [7:0] CODE_SKIP_RUN = 8'd255;
   localparam logic [7:0] CODE_ROW_END  = 8'd254;
   localparam logic [7:0] CODE_SKIP     = 8'd253;

   // request operations
   localparam logic OP_START = 1'b0;
   localparam logic OP_CODE  = 1'b1;

   typedef struct packed {
      logic       op;
      logic [7:0] code_byte;
      logic [7:0] under_pixel;
      logic [7:0] diagonal_pixel;
   } req_type;

   typedef struct packed {
      logic              write_enable;
      logic [ADDR_W-1:0] write_address;
      logic [7:0]        write_value;
      logic              extra_write_enable;
      logic [ADDR_W-1:0] extra_write_address;
      logic [7:0]        extra_write_value;
      logic [ADDR_W-1:0] cursor_address;
      logic              done_res;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  blend_mode;
      logic [3:0]  color_bank;
      logic [7:0]  brightness;
      logic [9:0]  sprite_width;
      logic [9:0]  sprite_height;
      logic [11:0] line_pitch;
      logic [11:0] origin_x;
      logic [11:0] origin_y;
   } cfg_type;

   // decoded work passed from front to back
   typedef struct packed {
      logic              pixel;
      logic [ADDR_W-1:0] pixel_address;
      logic [7:0]        code_byte;
      logic [7:0]        under_pixel;
      logic [7:0]        diagonal_pixel;
      logic [ADDR_W-1:0] cursor_address;
      logic              done;
   } cmd_type;

endpackage

>>> sv/rsb_front.sv
// ----------------------------------------------------------------------------
// rsb_front
// stream decoder: cursor, row and skip tracking; while accept is high, one code byte per cycle
// ----------------------------------------------------------------------------
module rsb_front import rsb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    accept,
   input  req_type req,
   output cmd_type cmd
);

   logic              pending_ff, pending_in;
   logic              finished_ff, finished_in;
   logic [15:0]       column_ff, column_in;
   logic [9:0]        row_ff, row_in;
   logic [ADDR_W-1:0] row_base_ff, row_base_in;
   logic [ADDR_W-1:0] cursor_ff, cursor_in;

   logic [23:0]       start_product;
   logic [ADDR_W-1:0] start_base;
   logic [ADDR_W-1:0] pitch_ext;
   logic [15:0]       column_step;
   logic [ADDR_W-1:0] cursor_step;
   logic              row_end_code;
   logic              width_test;
   logic              width_hit;

   assign start_product = cfg.origin_y * cfg.line_pitch;
   assign start_base    = ADDR_W'(start_product + 24'(cfg.origin_x));
   assign pitch_ext     = ADDR_W'(cfg.line_pitch);

   always_comb begin
      pending_in   = pending_ff;
      finished_in  = finished_ff;
      column_in    = column_ff;
      row_in       = row_ff;
      row_base_in  = row_base_ff;
      cursor_in    = cursor_ff;
      column_step  = column_ff;
      cursor_step  = cursor_ff;
      row_end_code = 1'b0;
      width_test   = 1'b1;
      width_hit    = 1'b0;

      cmd.pixel          = 1'b0;
      cmd.pixel_address  = cursor_ff;
      cmd.code_byte      = req.code_byte;
      cmd.under_pixel    = req.under_pixel;
      cmd.diagonal_pixel = req.diagonal_pixel;

      if (req.op == OP_START) begin
         row_base_in = start_base;
         cursor_in   = start_base;
         column_in   = '0;
         row_in      = '0;
         pending_in  = 1'b0;
         finished_in = (cfg.sprite_height == '0);
      end else if (!finished_ff) begin
         if (pending_ff) begin
            column_step = column_ff + 16'(req.code_byte);
            cursor_step = cursor_ff + ADDR_W'(req.code_byte);
            pending_in  = 1'b0;
         end else if (req.code_byte == CODE_SKIP_RUN) begin
            pending_in = 1'b1;
            width_test = 1'b0;
         end else if (req.code_byte == CODE_ROW_END) begin
            row_end_code = 1'b1;
            column_step  = '0;
         end else begin
            // plain skip and pixel both advance one column
            cmd.pixel   = (req.code_byte != CODE_SKIP);
            column_step = column_ff + 16'd1;
            cursor_step = cursor_ff + ADDR_W'(1);
         end

         width_hit = width_test && (column_step == 16'(cfg.sprite_width));

         column_in = column_step;
         cursor_in = cursor_step;
         // row end code and width hit may both fire on a zero width
         if (row_end_code && width_hit) begin
            row_base_in = row_base_ff + (pitch_ext << 1);
            row_in      = row_ff + 10'd2;
         end else if (row_end_code || width_hit) begin
            row_base_in = row_base_ff + pitch_ext;
            row_in      = row_ff + 10'd1;
         end
         if (row_end_code || width_hit) begin
            column_in = '0;
            cursor_in = row_base_in;
         end
         if (row_in >= cfg.sprite_height) begin
            finished_in = 1'b1;
         end
      end

      cmd.cursor_address = cursor_in;
      cmd.done           = finished_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff  <= 1'b0;
         finished_ff <= 1'b1;
         column_ff   <= '0;
         row_ff      <= '0;
         row_base_ff <= '0;
         cursor_ff   <= '0;
      end else if (accept) begin
         pending_ff  <= pending_in;
         finished_ff <= finished_in;
         column_ff   <= column_in;
         row_ff      <= row_in;
         row_base_ff <= row_base_in;
         cursor_ff   <= cursor_in;
      end
   end

endmodule

>>> sv/rsb_queue.sv
// ----------------------------------------------------------------------------
// rsb_queue
// two-entry command queue between decoder and blend stage
// ----------------------------------------------------------------------------
module rsb_queue import rsb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   input  logic    pop,
   output cmd_type pop_data,
   output logic    empty,
   output logic    full
);

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign empty    = (count_ff == 2'd0);
   assign full     = (count_ff == 2'd2);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> sv/rsb_back.sv
// ----------------------------------------------------------------------------
// rsb_back
// blend stage with registered result beat
// ----------------------------------------------------------------------------
module rsb_back import rsb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_payload_ff, rsp_payload_in;

   logic [7:0]        bank;
   logic [7:0]        bright;
   logic [7:0]        clamp_sum;
   logic [3:0]        clamp;
   logic [7:0]        value;
   logic [ADDR_W-1:0] extra_address;
   logic [7:0]        extra_source;

   function automatic logic [7:0] darken(input logic [7:0] v);
      return {v[7:4], 1'b0, v[3:1]};
   endfunction

   assign cmd_pop = cmd_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      bank      = {cfg.color_bank, 4'h0};
      bright    = ({4'h0, cmd.code_byte[3:0]} | bank) + cfg.brightness;
      clamp_sum = {4'h0, cmd.code_byte[3:0]} + cfg.brightness;
      if (clamp_sum >= 8'h1f) begin
         clamp = 4'h0;
      end else if (clamp_sum >= 8'h0f) begin
         clamp = 4'hf;
      end else begin
         clamp = clamp_sum[3:0];
      end

      unique case (cfg.blend_mode)
         MODE_SHADOW: value = 8'h00;
         MODE_DARKEN: value = darken(cmd.under_pixel);
         MODE_TRICK:  value = ({5'h0, cmd.under_pixel[3:1]} | {cmd.code_byte[7:4], 4'h0})
                              + {5'h0, cmd.code_byte[3:1]};
         MODE_MODIFY: value = ({5'h0, cmd.under_pixel[3:1]} | bank) + {5'h0, clamp[3:1]};
         MODE_ADJUST: value = {4'h0, clamp} | bank;
         default:     value = bright;
      endcase

      extra_address = cmd.pixel_address + ADDR_W'(1) + ADDR_W'(cfg.line_pitch);
      extra_source  = (extra_address == cmd.pixel_address) ? value : cmd.diagonal_pixel;

      rsp_payload_in                     = '0;
      rsp_payload_in.cursor_address      = cmd.cursor_address;
      rsp_payload_in.done_res            = cmd.done;
      if (cmd.pixel) begin
         rsp_payload_in.write_enable  = 1'b1;
         rsp_payload_in.write_address = cmd.pixel_address;
         rsp_payload_in.write_value   = value;
         if (cfg.blend_mode == MODE_BRIGHT_DARKEN) begin
            rsp_payload_in.extra_write_enable  = 1'b1;
            rsp_payload_in.extra_write_address = extra_address;
            rsp_payload_in.extra_write_value   = darken(extra_source);
         end
      end

      rsp_valid_in = cmd_pop || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

>>> sv/rle_sprite_blitter.sv
// ----------------------------------------------------------------------------
// rle_sprite_blitter
// run-length sprite decoder producing blended framebuffer writes
// ----------------------------------------------------------------------------
//  channel  ports                            direction  beat
//  req      req_valid req_stall req_payload  in         start or one code byte
//  rsp      rsp_valid rsp_stall rsp_payload  out        writes, cursor, done flag
//  csr      csr_valid csr_ready csr_index    in         one register write
//           csr_data
//
//  one request beat per cycle while req_stall is low; each beat gives exactly one response
//  each beat is registered in the queue, then blended into the output register
//  the decoder loop (column, row base, cursor) is registered on each accepted beat
//  synchronous active-high reset sets decoder state, queue and config registers to defaults
//  req_stall rises only when the two-entry queue is full; rsp_stall holds the
//  output register and backs up into the queue
// ----------------------------------------------------------------------------
module rle_sprite_blitter import rsb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_payload,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_payload,
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [11:0] csr_data
);

   cfg_type cfg_ff, cfg_in;

   logic    req_accept;
   cmd_type front_cmd;
   cmd_type queue_cmd;
   logic    queue_empty;
   logic    queue_full;
   logic    queue_pop;

   // register writes are always taken
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_BLEND_MODE:    cfg_in.blend_mode    = csr_data[2:0];
            CSR_COLOR_BANK:    cfg_in.color_bank    = csr_data[3:0];
            CSR_BRIGHTNESS:    cfg_in.brightness    = csr_data[7:0];
            CSR_SPRITE_WIDTH:  cfg_in.sprite_width  = csr_data[9:0];
            CSR_SPRITE_HEIGHT: cfg_in.sprite_height = csr_data[9:0];
            CSR_LINE_PITCH:    cfg_in.line_pitch    = csr_data;
            CSR_ORIGIN_X:      cfg_in.origin_x      = csr_data;
            CSR_ORIGIN_Y:      cfg_in.origin_y      = csr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.blend_mode    <= MODE_BRIGHT;
         cfg_ff.color_bank    <= '0;
         cfg_ff.brightness    <= '0;
         cfg_ff.sprite_width  <= 10'd1;
         cfg_ff.sprite_height <= 10'd1;
         cfg_ff.line_pitch    <= 12'd320;
         cfg_ff.origin_x      <= '0;
         cfg_ff.origin_y      <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front takes a beat whenever the queue has room
   assign req_stall  = queue_full;
   assign req_accept = req_valid && !queue_full;

   rsb_front u_front (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .accept (req_accept),
      .req    (req_payload),
      .cmd    (front_cmd)
   );

   rsb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (front_cmd),
      .pop       (queue_pop),
      .pop_data  (queue_cmd),
      .empty     (queue_empty),
      .full      (queue_full)
   );

   rsb_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .cmd_valid   (!queue_empty),
      .cmd         (queue_cmd),
      .cmd_pop     (queue_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
